// ----- hdl/slrt_pkg.sv -----
// ----------------------------------------------------------------------------
// slrt_pkg
// Types, constants and binary64 helpers for the step-length ratio test.
// ----------------------------------------------------------------------------
package slrt_pkg;

    localparam int MantW = 53;
    localparam int ExpW  = 13;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;
    localparam logic [63:0] MINUS_ONE = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] QNAN      = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DFLT_NAN  = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic [63:0] multiplier;
        logic [63:0] multiplier_step;
        logic [63:0] slack;
        logic [63:0] slack_step;
        logic        last_element;
    } item_t;

    typedef struct packed {
        logic [63:0] step_primal;
        logic [63:0] step_dual;
        logic [63:0] step_common;
    } result_t;

    typedef enum logic [1:0] {
        OP_NORM,
        OP_MUL,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

    function automatic logic is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        return x[62:0] == INF_MAG;
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    // Significand with the hidden bit, not yet normalized for subnormals.
    function automatic logic [MantW-1:0] unpack_mant(input logic [63:0] x);
        return {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    function automatic logic signed [ExpW-1:0] unpack_exp(input logic [63:0] x);
        logic signed [ExpW-1:0] e;
        if (x[62:52] == 11'd0)
        begin
            e = -13'sd1022;
        end
        else
        begin
            e = $signed({2'b00, x[62:52]}) - 13'sd1023;
        end
        return e;
    endfunction

    // a > b in IEEE order; false on NaN, zeros of either sign compare equal.
    function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (is_nan(a) || is_nan(b))
        begin
            r = 1'b0;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            r = 1'b0;
        end
        else if (a[63] != b[63])
        begin
            r = b[63];
        end
        else if (!a[63])
        begin
            r = a[62:0] > b[62:0];
        end
        else
        begin
            r = a[62:0] < b[62:0];
        end
        return r;
    endfunction

    // Round to nearest even and pack. n[55] is the leading one,
    // value = n / 2^55 * 2^e.
    function automatic logic [63:0] round_pack(input logic sgn,
                                               input logic signed [ExpW-1:0] e,
                                               input logic [55:0] n,
                                               input logic sticky);
        logic signed [13:0] be;
        logic signed [13:0] sh;
        logic [55:0]        sn;
        logic [56:0]        mask;
        logic               st;
        logic [10:0]        ef;
        logic               inc;
        logic [62:0]        body;
        logic [63:0]        r;
        be   = 14'(e) + 14'sd1023;
        sh   = 14'sd1 - be;
        sn   = n;
        st   = sticky;
        ef   = 11'd0;
        mask = 57'd0;
        if (be >= 14'sd2047)
        begin
            r = {sgn, INF_MAG};
        end
        else
        begin
            if (be <= 14'sd0)
            begin
                if (sh >= 14'sd57)
                begin
                    sn = 56'd0;
                    st = sticky | (|n);
                end
                else
                begin
                    mask = (57'd1 << sh[5:0]) - 57'd1;
                    sn   = n >> sh[5:0];
                    st   = sticky | (|({1'b0, n} & mask));
                end
            end
            else
            begin
                ef = be[10:0];
            end
            inc  = sn[2] & (sn[1] | sn[0] | st | sn[3]);
            body = {ef, sn[54:3]} + 63'(inc);
            r    = {sgn, body};
        end
        return r;
    endfunction

endpackage

// ----- hdl/slrt_stream_if.sv -----
// ----------------------------------------------------------------------------
// slrt_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface slrt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ipm_step_length_ratio_test_unit.sv -----
// ----------------------------------------------------------------------------
// ipm_step_length_ratio_test_unit
// Fraction-to-boundary ratio test on binary64 dual and primal bounds.
// ----------------------------------------------------------------------------
// Channel item carries one constraint word: multiplier, its step, slack,
// its step and a last flag. Channel result carries the negated primal bound,
// the negated dual bound and the negated larger of the two.
// Each word runs through the dual lane, then the primal lane, on one shared
// bit-serial unit that normalizes operands, multiplies and divides as each
// lane needs. item.ready is high only between words.
// On a last word the result is loaded into an output register and both
// bounds return to -1.0; the next word is taken while that result waits.
// If a previous result is still held the block waits for it to be taken.
// Reset sets both bounds to -1.0 and empties the output register.
// ----------------------------------------------------------------------------
module ipm_step_length_ratio_test_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    slrt_stream_if.sink          item,
    slrt_stream_if.source        result
);
    import slrt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CLASS  = 10'b00_0000_0010,
        ST_NORM_B = 10'b00_0000_0100,
        ST_NORM_S = 10'b00_0000_1000,
        ST_MUL    = 10'b00_0001_0000,
        ST_CMP    = 10'b00_0010_0000,
        ST_NORM_V = 10'b00_0100_0000,
        ST_NORM_D = 10'b00_1000_0000,
        ST_DIV    = 10'b01_0000_0000,
        ST_NEXT   = 10'b10_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        lane_reg, lane_next;
    logic [63:0] bdual_reg, bdual_next;
    logic [63:0] bprim_reg, bprim_next;
    item_t       item_reg, item_next;
    logic [52:0] mb_reg, mb_next;
    logic signed [ExpW-1:0] eb_reg, eb_next;
    logic signed [ExpW-1:0] es_reg, es_next;
    logic [52:0] mv_reg, mv_next;
    logic signed [ExpW-1:0] ev_reg, ev_next;
    logic [63:0] p_reg, p_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    iter_cmd_t   cmd;
    iter_sts_t   sts;
    logic [52:0] opa, opb;
    logic [105:0] acc;
    logic        rem_nz;
    logic [5:0]  cnt;

    logic [63:0] cur_b, cur_s, cur_v, new_bound;
    logic        bound_wr;
    logic signed [ExpW-1:0] cnt_s;
    logic signed [ExpW-1:0] pe, qe;
    logic [55:0] pn, qn;
    logic        pst, qst;
    logic        psgn, qsgn;
    logic [63:0] pick;

    slrt_iter_unit u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .sts    (sts),
        .acc    (acc),
        .rem_nz (rem_nz),
        .cnt    (cnt)
    );

    assign cur_b = lane_reg ? bprim_reg : bdual_reg;
    assign cur_s = lane_reg ? item_reg.slack_step : item_reg.multiplier_step;
    assign cur_v = lane_reg ? item_reg.slack : item_reg.multiplier;
    assign cnt_s = $signed({7'd0, cnt});
    assign psgn  = cur_b[63] ^ cur_s[63];
    assign qsgn  = cur_v[63] ^ cur_s[63];

    // align product and quotient to a leading one at bit 55
    always_comb
    begin
        if (acc[105])
        begin
            pe  = eb_reg + es_reg + 13'sd1;
            pn  = acc[105:50];
            pst = |acc[49:0];
        end
        else
        begin
            pe  = eb_reg + es_reg;
            pn  = acc[104:49];
            pst = |acc[48:0];
        end
        if (acc[56])
        begin
            qe  = ev_reg - es_reg;
            qn  = acc[56:1];
            qst = rem_nz | acc[0];
        end
        else
        begin
            qe  = ev_reg - es_reg - 13'sd1;
            qn  = acc[55:0];
            qst = rem_nz;
        end
    end

    assign pick = fp_gt(bprim_reg, bdual_reg) ? bprim_reg : bdual_reg;

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        item_next      = item_reg;
        mb_next        = mb_reg;
        eb_next        = eb_reg;
        es_next        = es_reg;
        mv_next        = mv_reg;
        ev_next        = ev_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & ~result.ready;
        bound_wr       = 1'b0;
        new_bound      = cur_b;
        bdual_next     = bdual_reg;
        bprim_next     = bprim_reg;
        cmd.start      = 1'b0;
        cmd.op         = OP_NORM;
        opa            = unpack_mant(cur_b);
        opb            = 53'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    item_next  = item.data;
                    lane_next  = 1'b0;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (is_nan(cur_b) || is_nan(cur_s) || (is_inf(cur_b) && is_zero(cur_s))
                    || (is_zero(cur_b) && is_inf(cur_s)))
                begin
                    p_next     = QNAN;
                    state_next = ST_CMP;
                end
                else if (is_inf(cur_b) || is_inf(cur_s))
                begin
                    p_next     = {psgn, INF_MAG};
                    state_next = ST_CMP;
                end
                else if (is_zero(cur_b) || is_zero(cur_s))
                begin
                    p_next     = {psgn, 63'd0};
                    state_next = ST_CMP;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_NORM_B;
                end
            end
            ST_NORM_B:
            begin
                if (sts.done)
                begin
                    mb_next    = acc[52:0];
                    eb_next    = unpack_exp(cur_b) - cnt_s;
                    cmd.start  = 1'b1;
                    opa        = unpack_mant(cur_s);
                    state_next = ST_NORM_S;
                end
            end
            ST_NORM_S:
            begin
                if (sts.done)
                begin
                    es_next    = unpack_exp(cur_s) - cnt_s;
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    opa        = mb_reg;
                    opb        = acc[52:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.done)
                begin
                    p_next     = round_pack(psgn, pe, pn, pst);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (!fp_gt(p_reg, cur_v))
                begin
                    state_next = ST_NEXT;
                end
                else if (is_zero(cur_s))
                begin
                    bound_wr   = 1'b1;
                    new_bound  = {qsgn, INF_MAG};
                    state_next = ST_NEXT;
                end
                else if (is_inf(cur_v) && is_inf(cur_s))
                begin
                    bound_wr   = 1'b1;
                    new_bound  = DFLT_NAN;
                    state_next = ST_NEXT;
                end
                else if (is_inf(cur_v))
                begin
                    bound_wr   = 1'b1;
                    new_bound  = {qsgn, INF_MAG};
                    state_next = ST_NEXT;
                end
                else if (is_zero(cur_v) || is_inf(cur_s))
                begin
                    bound_wr   = 1'b1;
                    new_bound  = {qsgn, 63'd0};
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    opa        = unpack_mant(cur_v);
                    state_next = ST_NORM_V;
                end
            end
            ST_NORM_V:
            begin
                if (sts.done)
                begin
                    mv_next    = acc[52:0];
                    ev_next    = unpack_exp(cur_v) - cnt_s;
                    cmd.start  = 1'b1;
                    opa        = unpack_mant(cur_s);
                    state_next = ST_NORM_D;
                end
            end
            ST_NORM_D:
            begin
                if (sts.done)
                begin
                    es_next    = unpack_exp(cur_s) - cnt_s;
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    opa        = mv_reg;
                    opb        = acc[52:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.done)
                begin
                    bound_wr   = 1'b1;
                    new_bound  = round_pack(qsgn, qe, qn, qst);
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!lane_reg)
                begin
                    lane_next  = 1'b1;
                    state_next = ST_CLASS;
                end
                else if (!item_reg.last_element)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_valid_reg || result.ready)
                begin
                    // emit the word and restart both bounds
                    res_next.step_primal = bprim_reg ^ SIGN_MASK;
                    res_next.step_dual   = bdual_reg ^ SIGN_MASK;
                    res_next.step_common = pick ^ SIGN_MASK;
                    res_valid_next       = 1'b1;
                    bdual_next           = MINUS_ONE;
                    bprim_next           = MINUS_ONE;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (bound_wr)
        begin
            if (lane_reg)
            begin
                bprim_next = new_bound;
            end
            else
            begin
                bdual_next = new_bound;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_reg      <= 1'b0;
            bdual_reg     <= MINUS_ONE;
            bprim_reg     <= MINUS_ONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            bdual_reg     <= bdual_next;
            bprim_reg     <= bprim_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mb_reg   <= mb_next;
        eb_reg   <= eb_next;
        es_reg   <= es_next;
        mv_reg   <= mv_next;
        ev_reg   <= ev_next;
        p_reg    <= p_next;
        res_reg  <= res_next;
    end

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

// ----- hdl/slrt_iter_unit.sv -----
// ----------------------------------------------------------------------------
// slrt_iter_unit
// Shared one-bit-per-cycle significand unit: normalize, multiply, divide.
// ----------------------------------------------------------------------------
module slrt_iter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  slrt_pkg::iter_cmd_t cmd,
    input  logic [52:0]         opa,
    input  logic [52:0]         opb,
    output slrt_pkg::iter_sts_t sts,
    output logic [105:0]        acc,
    output logic                rem_nz,
    output logic [5:0]          cnt
);
    import slrt_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    iter_op_t    op_reg;
    logic [105:0] acc_reg, acc_next;
    logic [52:0] b_reg;
    logic [53:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [53:0] sum;
    logic        qbit;
    logic [53:0] rdiff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        sum       = {1'b0, acc_reg[105:53]} + (acc_reg[0] ? {1'b0, b_reg} : 54'd0);
        qbit      = rem_reg >= {1'b0, b_reg};
        rdiff     = qbit ? (rem_reg - {1'b0, b_reg}) : rem_reg;
        if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    acc_next = {sum, acc_reg[52:1]};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd52)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_DIV:
                begin
                    acc_next = {49'd0, acc_reg[55:0], qbit};
                    rem_next = {rdiff[52:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd56)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    // shift until the leading one reaches the top
                    if (acc_reg[52] || cnt_reg == 6'd52)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = {53'd0, acc_reg[51:0], 1'b0};
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            endcase
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = {1'b0, opa};
            acc_next  = (cmd.op == OP_DIV) ? 106'd0 : {53'd0, opa};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!busy_reg && cmd.start)
        begin
            op_reg <= cmd.op;
            b_reg  <= opb;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc      = acc_reg;
    assign rem_nz   = |rem_reg;
    assign cnt      = cnt_reg;

endmodule

// ----- hdl/slrt_checker.sv -----
// ----------------------------------------------------------------------------
// slrt_checker
// Port-level checks on the ratio-test unit, bound to the top level.
// ----------------------------------------------------------------------------
module slrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_primal,
    input logic [63:0] res_dual,
    input logic [63:0] res_common
);
    // a stalled result stays valid and its common bound holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_common))
        else $error("result word changed while stalled");

    // the block is busy right after taking a word
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after accepting a word");

    // a new result never shows up the cycle after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !res_valid |=> !res_valid)
        else $error("result appeared too early");

    // common bound is one of the two bounds
    a_common_pick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_common == res_primal) || (res_common == res_dual))
        else $error("common bound matches neither lane");
endmodule

bind ipm_step_length_ratio_test_unit slrt_checker u_slrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_primal (result.data.step_primal),
    .res_dual   (result.data.step_dual),
    .res_common (result.data.step_common)
);
